>>> rtl/core/hmhq_pkg.sv
// Shared types and constants for the heightmap height query block.
package hmhq_pkg;

    localparam int MAX_GRID_DEF = 256;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_INTERP = 2'd1;
    localparam logic [1:0] OP_VERTEX = 2'd2;

    localparam logic CFG_GRID_SIZE    = 1'b0;
    localparam logic CFG_HEIGHT_SCALE = 1'b1;

    typedef enum logic [1:0] {
        C_BL    = 2'd0,
        C_OTHER = 2'd1,
        C_TR    = 2'd2
    } corner_t;

    typedef enum logic [1:0] {
        W_BL     = 2'd0,
        W_OTHER  = 2'd1,
        W_TR     = 2'd2,
        W_VERTEX = 2'd3
    } weight_t;

    // height = (w * scale + ROUND_BIAS) / (256 * DIV_LOW), saturated
    localparam logic [31:0] ROUND_BIAS = 32'd32640;
    localparam logic [23:0] SAT_LIMIT  = 24'd16711680;
    localparam logic [32:0] RECIP_MUL  = 33'd257;
    localparam logic [25:0] DIV_LOW    = 26'd255;
    localparam logic [25:0] DIV_LOW2   = 26'd510;

    typedef struct packed {
        logic    capture;
        logic    acc_clr;
        logic    mem_wr;
        logic    mem_rd;
        corner_t csel;
        logic    acc_en;
        weight_t wsel;
        logic    mul_en;
        logic    div_en;
        logic    res_en;
        logic    res_zero;
        logic    res_oor;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       interp_oor;
        logic       vertex_oor;
        logic       load_ok;
    } status_t;

endpackage

>>> rtl/core/heightmap_height_query.sv
// From accept to done strobe: load and out-of-range requests end after decode; vertex and interpolated ones go on.
// One item at a time; a new start is taken the cycle busy drops.
// Interpolated: decode, three serial store reads, last blend, scale, two divide steps, output.
// Results are strobed on done for one cycle; the receiver cannot stall.
// rst_n is asynchronous: grid_size=min(256,MAX_GRID), height_scale=256; samples are not cleared.
module heightmap_height_query
    import hmhq_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    input  logic [7:0]  sample,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_z,
    output logic        done,
    output logic [15:0] height,
    output logic        out_of_range
);

    cmd_t    cmd;
    status_t sts;

    assign cfg_ready = 1'b1;

    hmhq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    hmhq_datapath #(
        .MAX_GRID (MAX_GRID)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .row          (row),
        .column       (column),
        .sample       (sample),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .cmd          (cmd),
        .sts          (sts),
        .height       (height),
        .out_of_range (out_of_range),
        .done         (done)
    );

endmodule

>>> rtl/core/hmhq_datapath.sv
// Datapath: config registers, sample store, weighted blend, scale and divide.
module hmhq_datapath
    import hmhq_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  opcode,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    input  logic [7:0]  sample,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_z,
    input  cmd_t        cmd,
    output status_t     sts,
    output logic [15:0] height,
    output logic        out_of_range,
    output logic        done
);

    localparam int NW    = $clog2(MAX_GRID + 1);
    localparam int GW    = (NW > 9) ? NW : 9;
    localparam int DEPTH = MAX_GRID * MAX_GRID;
    localparam int AW    = $clog2(DEPTH);
    localparam int NRST  = (MAX_GRID < 256) ? MAX_GRID : 256;

    logic [NW-1:0] n_reg, n_next;
    logic [15:0]   scale_reg;

    logic [1:0]  op_reg;
    logic [7:0]  row_reg, col_reg, smp_reg;
    logic [7:0]  x_reg, u_reg, z_reg, v_reg;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rd_data_reg;

    logic [15:0] acc_reg, acc_next;
    logic [31:0] prod_reg;
    logic [23:0] t_reg;
    logic [16:0] q1_reg;
    logic        sat_reg;
    logic [15:0] height_reg, height_next;
    logic        oor_reg, oor_next;
    logic        done_reg;

    logic [GW-1:0] gs, nx, xg, zg;
    logic          upper;
    logic [8:0]    x9, z9, x1, z1, rd_r, rd_c;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [8:0]    weight;
    logic [16:0]   mac_prod;
    logic [31:0]   p_sum;
    logic [23:0]   t_next;
    logic [32:0]   t_mul;
    logic [25:0]   rem;
    logic [16:0]   q_fix;

    // grid size clamp on write
    always_comb
    begin
        gs = GW'(cfg_data[8:0]);
        if (gs < GW'(2))
            n_next = NW'(2);
        else if (gs > GW'(MAX_GRID))
            n_next = NW'(MAX_GRID);
        else
            n_next = NW'(gs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= NW'(NRST);
            scale_reg <= 16'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_SIZE:    n_reg     <= n_next;
                CFG_HEIGHT_SCALE: scale_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            row_reg <= row;
            col_reg <= column;
            smp_reg <= sample;
            x_reg   <= pos_x[15:8];
            u_reg   <= pos_x[7:0];
            z_reg   <= pos_z[15:8];
            v_reg   <= pos_z[7:0];
        end
    end

    always_comb
    begin
        nx = GW'(n_reg);
        xg = GW'(x_reg);
        zg = GW'(z_reg);
        sts.op         = op_reg;
        sts.interp_oor = (x_reg == 8'd0) || (z_reg == 8'd0) ||
                         (xg + GW'(1) >= nx) || (zg + GW'(1) >= nx);
        sts.vertex_oor = (xg >= nx) || (zg >= nx);
        sts.load_ok    = (GW'(row_reg) < nx) && (GW'(col_reg) < nx);
    end

    // corner selection
    always_comb
    begin
        upper = u_reg > v_reg;
        x9 = {1'b0, x_reg};
        z9 = {1'b0, z_reg};
        x1 = x9 + 9'd1;
        z1 = z9 + 9'd1;
        case (cmd.csel)
            C_BL:
            begin
                rd_r = z9;
                rd_c = x9;
            end
            C_OTHER:
            begin
                rd_r = upper ? z9 : z1;
                rd_c = upper ? x1 : x9;
            end
            C_TR:
            begin
                rd_r = z1;
                rd_c = x1;
            end
            default:
            begin
                rd_r = z9;
                rd_c = x9;
            end
        endcase
        rd_addr = AW'(rd_r) * AW'(MAX_GRID) + AW'(rd_c);
        wr_addr = AW'(row_reg) * AW'(MAX_GRID) + AW'(col_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[wr_addr] <= smp_reg;
        if (cmd.mem_rd)
            rd_data_reg <= mem[rd_addr];
    end

    // blend weights
    always_comb
    begin
        case (cmd.wsel)
            W_BL:     weight = 9'd256 - {1'b0, (upper ? u_reg : v_reg)};
            W_OTHER:  weight = upper ? {1'b0, u_reg - v_reg} : {1'b0, v_reg - u_reg};
            W_TR:     weight = {1'b0, (upper ? v_reg : u_reg)};
            W_VERTEX: weight = 9'd256;
            default:  weight = 9'd0;
        endcase
        mac_prod = 17'(rd_data_reg) * 17'(weight);
        if (cmd.acc_clr)
            acc_next = 16'd0;
        else
            acc_next = acc_reg + mac_prod[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr || cmd.acc_en)
            acc_reg <= acc_next;
        if (cmd.mul_en)
            prod_reg <= 32'(acc_reg) * 32'(scale_reg);
        if (cmd.div_en)
        begin
            t_reg   <= t_next;
            q1_reg  <= t_mul[32:16];
            sat_reg <= t_next >= SAT_LIMIT;
        end
    end

    // divide by 65280: shift by 8, then reciprocal of 255 with correction
    always_comb
    begin
        p_sum  = prod_reg + ROUND_BIAS;
        t_next = p_sum[31:8];
        t_mul  = 33'(t_next) * RECIP_MUL;
        rem    = 26'(t_reg) - 26'(q1_reg) * DIV_LOW;
        if (rem >= DIV_LOW2)
            q_fix = q1_reg + 17'd2;
        else if (rem >= DIV_LOW)
            q_fix = q1_reg + 17'd1;
        else
            q_fix = q1_reg;
        if (cmd.res_zero)
        begin
            height_next = 16'd0;
            oor_next    = cmd.res_oor;
        end
        else
        begin
            height_next = sat_reg ? 16'hFFFF : q_fix[15:0];
            oor_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_en)
        begin
            height_reg <= height_next;
            oor_reg    <= oor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.res_en;
    end

    assign height       = height_reg;
    assign out_of_range = oor_reg;
    assign done         = done_reg;

endmodule

>>> rtl/core/hmhq_ctrl.sv
// Controller: sequences decode, corner reads, blend, scale, divide and result.
module hmhq_ctrl
    import hmhq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t sts,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_RD0    = 9'b000000100,
        S_RD1    = 9'b000001000,
        S_RD2    = 9'b000010000,
        S_ACC    = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_DIV1   = 9'b010000000,
        S_DIV2   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.csel   = C_BL;
        cmd.wsel   = W_BL;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.acc_clr = 1'b1;
                case (sts.op)
                    OP_LOAD:
                    begin
                        cmd.mem_wr   = sts.load_ok;
                        cmd.res_en   = 1'b1;
                        cmd.res_zero = 1'b1;
                        state_next   = S_IDLE;
                    end
                    OP_INTERP:
                    begin
                        if (sts.interp_oor)
                        begin
                            cmd.res_en   = 1'b1;
                            cmd.res_zero = 1'b1;
                            cmd.res_oor  = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                            state_next = S_RD0;
                    end
                    OP_VERTEX:
                    begin
                        if (sts.vertex_oor)
                        begin
                            cmd.res_en   = 1'b1;
                            cmd.res_zero = 1'b1;
                            cmd.res_oor  = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                            state_next = S_RD0;
                    end
                    default:
                    begin
                        cmd.res_en   = 1'b1;
                        cmd.res_zero = 1'b1;
                        state_next   = S_IDLE;
                    end
                endcase
            end
            S_RD0:
            begin
                cmd.mem_rd = 1'b1;
                cmd.csel   = C_BL;
                state_next = (sts.op == OP_VERTEX) ? S_ACC : S_RD1;
            end
            S_RD1:
            begin
                cmd.mem_rd = 1'b1;
                cmd.csel   = C_OTHER;
                cmd.acc_en = 1'b1;
                cmd.wsel   = W_BL;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.mem_rd = 1'b1;
                cmd.csel   = C_TR;
                cmd.acc_en = 1'b1;
                cmd.wsel   = W_OTHER;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                cmd.wsel   = (sts.op == OP_VERTEX) ? W_VERTEX : W_TR;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.div_en = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.res_en = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> dv/tb.sv
// Testbench for heightmap_height_query: directed table, then random phases checked by a grid model.
module tb;
    import hmhq_pkg::*;

    localparam int HALF = 6;
    localparam int STRIDE = MAX_GRID_DEF;
    localparam int SAMPLES = MAX_GRID_DEF * MAX_GRID_DEF;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 200;
    localparam int MAX_GAP = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 600000;
    localparam longint ROUND_HALF = 32640;
    localparam longint FULL_SAMPLE = 65280;

    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  r;
        logic [7:0]  c;
        logic [7:0]  s;
        logic [15:0] px;
        logic [15:0] pz;
    } word_t;

    typedef struct packed {
        logic [15:0] h;
        logic        oor;
    } height_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        word_t       w;
        logic        reg_idx;
        logic [15:0] reg_val;
        logic        typed;
        height_t     known;
    } step_t;

    localparam word_t NO_WORD = '0;
    localparam height_t FLAT = '{16'd0, 1'b0};
    localparam height_t OFF_GRID = '{16'd0, 1'b1};
    localparam height_t TOP = '{16'd256, 1'b0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_GRID_SIZE;
    logic [15:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = OP_LOAD;
    logic [7:0]  row = '0;
    logic [7:0]  column = '0;
    logic [7:0]  sample = '0;
    logic [15:0] pos_x = '0;
    logic [15:0] pos_z = '0;
    logic        done;
    logic [15:0] height;
    logic        out_of_range;

    logic [7:0]  hstore [SAMPLES];
    bit          written [SAMPLES];
    logic [8:0]  grid_now = 9'd256;
    logic [15:0] scale_now = 16'd256;
    height_t     heights_due [$];
    int          mismatches = 0;

    int          idle_pct [3] = '{0, 86, 30};
    logic [8:0]  grid_plan [PHASES] = '{9'd256, 9'd2, 9'd5, 9'd511, 9'd1, 9'd40, 9'd255, 9'd257};
    logic [15:0] scale_plan [PHASES] = '{16'd256, 16'd65535, 16'd0, 16'd1, 16'd255, 16'd4321,
                                         16'hFFFF, 16'd300};

    // corners (1,1) (1,2) (2,1) (2,2) first, then edges, then grid clamping
    step_t directed [31] = '{
        '{ROW_WORD, '{OP_LOAD, 8'd1, 8'd1, 8'd255, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_LOAD, 8'd1, 8'd2, 8'd255, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_LOAD, 8'd2, 8'd1, 8'd255, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_LOAD, 8'd2, 8'd2, 8'd255, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h0180, 16'h0140}, 1'b0, 16'd0, 1'b1, TOP},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h0140, 16'h0180}, 1'b0, 16'd0, 1'b1, TOP},
        '{ROW_WORD, '{OP_LOAD, 8'd2, 8'd2, 8'd0, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_LOAD, 8'd1, 8'd2, 8'd17, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_LOAD, 8'd2, 8'd1, 8'd200, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h01C0, 16'h0140}, 1'b0, 16'd0, 1'b0, FLAT},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h0140, 16'h01C0}, 1'b0, 16'd0, 1'b0, FLAT},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h0133, 16'h0133}, 1'b0, 16'd0, 1'b0, FLAT},
        '{ROW_WORD, '{OP_VERTEX, 8'd0, 8'd0, 8'd0, 16'h0100, 16'h0100}, 1'b0, 16'd0, 1'b1, TOP},
        '{ROW_WORD, '{OP_LOAD, 8'd255, 8'd255, 8'd255, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1,
          FLAT},
        '{ROW_WORD, '{OP_LOAD, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_VERTEX, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF}, 1'b0, 16'd0, 1'b1, TOP},
        '{ROW_WORD, '{OP_VERTEX, 8'd0, 8'd0, 8'd0, 16'h00FF, 16'h00FF}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h00FF, 16'h0180}, 1'b0, 16'd0, 1'b1,
          OFF_GRID},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h0180, 16'h0080}, 1'b0, 16'd0, 1'b1,
          OFF_GRID},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'hFF00, 16'h0180}, 1'b0, 16'd0, 1'b1,
          OFF_GRID},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h0180, 16'hFFFF}, 1'b0, 16'd0, 1'b1,
          OFF_GRID},
        '{ROW_WORD, '{OP_NONE, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF}, 1'b0, 16'd0, 1'b1,
          FLAT},
        '{ROW_REG, NO_WORD, CFG_GRID_SIZE, 16'd0, 1'b0, FLAT},
        '{ROW_REG, NO_WORD, CFG_HEIGHT_SCALE, 16'd65535, 1'b0, FLAT},
        // row 2 is outside a 2x2 grid: dropped, (2,1) keeps 200
        '{ROW_WORD, '{OP_LOAD, 8'd2, 8'd1, 8'd9, 16'h0000, 16'h0000}, 1'b0, 16'd0, 1'b1, FLAT},
        '{ROW_WORD, '{OP_VERTEX, 8'd0, 8'd0, 8'd0, 16'h0101, 16'h0100}, 1'b0, 16'd0, 1'b1,
          '{16'd65535, 1'b0}},
        '{ROW_WORD, '{OP_VERTEX, 8'd0, 8'd0, 8'd0, 16'h0200, 16'h0000}, 1'b0, 16'd0, 1'b1,
          OFF_GRID},
        '{ROW_WORD, '{OP_INTERP, 8'd0, 8'd0, 8'd0, 16'h0180, 16'h0180}, 1'b0, 16'd0, 1'b1,
          OFF_GRID},
        '{ROW_REG, NO_WORD, CFG_GRID_SIZE, 16'd511, 1'b0, FLAT},
        '{ROW_REG, NO_WORD, CFG_HEIGHT_SCALE, 16'd255, 1'b0, FLAT},
        '{ROW_WORD, '{OP_VERTEX, 8'd0, 8'd0, 8'd0, 16'h0100, 16'h0200}, 1'b0, 16'd0, 1'b1,
          '{16'd200, 1'b0}}
    };

    heightmap_height_query i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .row          (row),
        .column       (column),
        .sample       (sample),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .done         (done),
        .height       (height),
        .out_of_range (out_of_range)
    );

    always #HALF clk = ~clk;

    function automatic int eff_grid();
        if (grid_now < 9'd2)
            return 2;
        if (grid_now > 9'(MAX_GRID_DEF))
            return MAX_GRID_DEF;
        return int'(grid_now);
    endfunction

    function automatic logic [15:0] scaled(longint acc);
        longint t;
        t = (acc * longint'(scale_now) + ROUND_HALF) / FULL_SAMPLE;
        return (t > 65535) ? 16'hFFFF : 16'(t);
    endfunction

    function automatic height_t query_grid(word_t w);
        int n, x, z, u, v, bl, br, tl, tr;
        longint acc;
        height_t res;
        n = eff_grid();
        x = int'(w.px[15:8]);
        u = int'(w.px[7:0]);
        z = int'(w.pz[15:8]);
        v = int'(w.pz[7:0]);
        res = FLAT;
        case (w.op)
            OP_LOAD:
                if (int'(w.r) < n && int'(w.c) < n)
                begin
                    hstore[int'(w.r) * STRIDE + int'(w.c)] = w.s;
                    written[int'(w.r) * STRIDE + int'(w.c)] = 1'b1;
                end
            OP_INTERP:
                if (x == 0 || z == 0 || x + 1 >= n || z + 1 >= n)
                    res.oor = 1'b1;
                else
                begin
                    bl = int'(hstore[z * STRIDE + x]);
                    br = int'(hstore[z * STRIDE + x + 1]);
                    tl = int'(hstore[(z + 1) * STRIDE + x]);
                    tr = int'(hstore[(z + 1) * STRIDE + x + 1]);
                    if (u > v)
                        acc = br * (u - v) + tr * v + bl * (256 - u);
                    else
                        acc = tl * (v - u) + tr * u + bl * (256 - v);
                    res.h = scaled(acc);
                end
            OP_VERTEX:
                if (x >= n || z >= n)
                    res.oor = 1'b1;
                else
                    res.h = scaled(longint'(hstore[z * STRIDE + x]) * 256);
            default: ;
        endcase
        return res;
    endfunction

    // address of a sample the query would read before it was ever loaded, or -1
    function automatic int first_unwritten(word_t w);
        int n, x, z;
        n = eff_grid();
        x = int'(w.px[15:8]);
        z = int'(w.pz[15:8]);
        if (w.op == OP_VERTEX && x < n && z < n)
        begin
            if (!written[z * STRIDE + x])
                return z * STRIDE + x;
        end
        else if (w.op == OP_INTERP && x > 0 && z > 0 && x + 1 < n && z + 1 < n)
        begin
            for (int dz = 0; dz < 2; dz++)
                for (int dx = 0; dx < 2; dx++)
                    if (!written[(z + dz) * STRIDE + x + dx])
                        return (z + dz) * STRIDE + x + dx;
        end
        return -1;
    endfunction

    function automatic logic [7:0] pick_cell(int n, int hot_lo);
        int r, v;
        r = $urandom_range(99);
        if (r < 55)
            v = hot_lo + $urandom_range(5);
        else if (r < 75)
        begin
            case ($urandom_range(5))
                0: v = 0;
                1: v = 1;
                2: v = n - 2;
                3: v = n - 1;
                4: v = n;
                default: v = 255;
            endcase
        end
        else
            v = $urandom_range(255);
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic logic [7:0] pick_frac();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // queries that would touch unloaded samples turn into a load of that sample
    function automatic word_t make_word(int n, int hot_lo);
        word_t w;
        int k, a;
        logic [7:0] u, v;
        k = $urandom_range(99);
        if (k < 28)
            w.op = OP_LOAD;
        else if (k < 63)
            w.op = OP_INTERP;
        else if (k < 94)
            w.op = OP_VERTEX;
        else
            w.op = OP_NONE;
        w.r = pick_cell(n, hot_lo);
        w.c = pick_cell(n, hot_lo);
        w.s = 8'($urandom_range(255));
        u = pick_frac();
        v = ($urandom_range(4) == 0) ? u : pick_frac();
        w.px = {pick_cell(n, hot_lo), u};
        w.pz = {pick_cell(n, hot_lo), v};
        a = first_unwritten(w);
        if (a >= 0)
        begin
            w.op = OP_LOAD;
            w.r = 8'(a / STRIDE);
            w.c = 8'(a % STRIDE);
        end
        return w;
    endfunction

    task automatic send_word(word_t w, int pct, bit typed, height_t known);
        int gap;
        height_t res;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        opcode <= w.op;
        row    <= w.r;
        column <= w.c;
        sample <= w.s;
        pos_x  <= w.px;
        pos_z  <= w.pz;
        do @(posedge clk); while (busy);
        res = query_grid(w);
        heights_due.insert(heights_due.size(), typed ? known : res);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (heights_due.size() != 0 || busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_GRID_SIZE)
            grid_now = val[8:0];
        else
            scale_now = val;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        height_t want;
        if (rst_n && done)
        begin
            if (heights_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word: height=%0d out_of_range=%0b",
                         $time, height, out_of_range);
            end
            else
            begin
                want = heights_due.pop_front();
                if (height !== want.h)
                begin
                    mismatches++;
                    $display("%0t: height expected %0d, got %0d", $time, want.h, height);
                end
                if (out_of_range !== want.oor)
                begin
                    mismatches++;
                    $display("%0t: out_of_range expected %0b, got %0b",
                             $time, want.oor, out_of_range);
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int n, hot_lo;
        word_t w;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_REG)
            begin
                settle();
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            end
            else
                send_word(directed[i].w, 0, directed[i].typed, directed[i].known);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_reg(CFG_GRID_SIZE,
                      {($urandom_range(1) != 0) ? 7'($urandom) : 7'd0, grid_plan[p]});
            write_reg(CFG_HEIGHT_SCALE, scale_plan[p]);
            n = eff_grid();
            hot_lo = $urandom_range(1, (n > 8) ? n - 7 : 1);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                w = make_word(n, hot_lo);
                send_word(w, idle_pct[p % 3], 1'b0, FLAT);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
